// ===== hw/rtl/depth_forward_warp_zbuffer_top_macros.svh =====
// Assertion shorthands shared by the warp block's modules.
// Each one is clocked on clk and is switched off while rst_n is low.
`ifndef DEPTH_FORWARD_WARP_ZBUFFER_TOP_MACROS_SVH
`define DEPTH_FORWARD_WARP_ZBUFFER_TOP_MACROS_SVH

// A property that must hold at every clock edge.
`define DFW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define DFW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dfw_pkg.sv =====
package dfw_pkg;

  localparam int DATA_W    = 16;
  localparam int COORD_W   = 9;
  localparam int SIZE_W    = 10;
  localparam int COMP_W    = 2;
  localparam int CFG_IDX_W = 3;
  // Frame tag kept with every store entry; tag zero marks an entry as empty.
  localparam int TAG_W     = 8;
  // Disparity times offset, plus the rounding term, plus a guard bit.
  localparam int PROD_W    = 34;
  // Target coordinate after the shift is added.
  localparam int POS_W     = 36;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_WARP  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COL_OFFSET   = 3'd0,
    REG_ROW_OFFSET   = 3'd1,
    REG_DEPTH_OFFSET = 3'd2,
    REG_ROWS_IN_USE  = 3'd3,
    REG_COLS_IN_USE  = 3'd4,
    REG_COMPONENTS   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] col_offset;
    logic signed [DATA_W-1:0] row_offset;
    logic [DATA_W-1:0]        depth_offset;
    logic [SIZE_W-1:0]        rows_in_use;
    logic [SIZE_W-1:0]        cols_in_use;
    logic [COMP_W-1:0]        components;
  } cfg_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_MUL,
    S_ADDR,
    S_RD,
    S_UPD,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic epoch_step;
    logic mul;
    logic addr;
    logic use_shift;
    logic rd;
    logic upd;
    logic resp;
    logic sweep;
  } cmd_t;

  typedef struct packed {
    logic epoch_max;
    logic sweep_last;
    logic out_busy;
  } status_t;

endpackage

// ===== hw/rtl/dfw_ctrl.sv =====
`include "depth_forward_warp_zbuffer_top_macros.svh"

module dfw_ctrl
  import dfw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [1:0]  in_action,
  output logic        in_stall,
  input  status_t     status,
  output cmd_t        cmd
);

  state_t  state_r, state_nxt;
  action_t act_r, act_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
      act_r   <= ACT_NONE;
    end else begin
      state_r <= state_nxt;
      act_r   <= act_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    act_nxt   = act_r;
    in_stall  = 1'b1;
    unique case (state_r)
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          act_nxt  = action_t'(in_action);
          unique case (action_t'(in_action))
            ACT_START: begin
              // Running out of frame tags forces a full sweep of the store.
              cmd.epoch_step = 1'b1;
              if (status.epoch_max) begin
                state_nxt = S_SWEEP;
              end
            end
            ACT_WARP: state_nxt = S_MUL;
            ACT_READ: state_nxt = S_ADDR;
            ACT_NONE: state_nxt = S_IDLE;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr      = 1'b1;
        cmd.use_shift = (act_r == ACT_WARP);
        state_nxt     = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = (act_r == ACT_WARP) ? S_UPD : S_RESP;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RESP: begin
        if (!status.out_busy) begin
          cmd.resp  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `DFW_ASSERT(a_cmd_onehot, $onehot0({cmd.sweep, cmd.mul, cmd.addr, cmd.rd, cmd.upd, cmd.resp}), "datapath steps overlap")
  `DFW_ASSERT(a_resp_free, !cmd.resp || !status.out_busy, "result written over a waiting word")
  `DFW_ASSERT_NEXT(a_wrap_sweep, cmd.epoch_step && status.epoch_max, state_r == S_SWEEP, "tag wrap without sweep")

endmodule

// ===== hw/rtl/dfw_dp.sv =====
`include "depth_forward_warp_zbuffer_top_macros.svh"

module dfw_dp
  import dfw_pkg::*;
#(
  parameter int MAX_ROWS        = 512,
  parameter int MAX_COLS        = 512,
  parameter int DEPTH_FRAC_BITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            status,
  input  cfg_t               cfg,
  input  logic [COORD_W-1:0] in_row,
  input  logic [COORD_W-1:0] in_col,
  input  logic [DATA_W-1:0]  in_pixel_depth,
  input  logic [DATA_W-1:0]  in_color_a,
  input  logic [DATA_W-1:0]  in_color_b,
  input  logic [DATA_W-1:0]  in_color_c,
  input  logic               out_stall,
  output logic               out_valid,
  output logic               out_filled,
  output logic [DATA_W-1:0]  out_depth,
  output logic [DATA_W-1:0]  out_color_a,
  output logic [DATA_W-1:0]  out_color_b,
  output logic [DATA_W-1:0]  out_color_c
);

  localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ADDR_W  = ROW_W + COL_W;
  localparam int DEPTH_N = 1 << ADDR_W;
  localparam int RND     = DEPTH_FRAC_BITS + 8;
  localparam int WORD_W  = TAG_W + 4 * DATA_W;
  localparam logic [PROD_W-1:0] HALF = PROD_W'((64'd1 << RND) >> 1);

  // Accepted word.
  logic [COORD_W-1:0]      row_r, col_r;
  logic [DATA_W-1:0]       depth_r, col_a_r, col_b_r, col_c_r;
  logic signed [DATA_W:0]  disp_r;
  // Products and target.
  logic signed [PROD_W-1:0] prod_row_r, prod_col_r;
  logic [ADDR_W-1:0]        addr_r;
  logic                     in_range_r;
  logic [WORD_W-1:0]        rd_word_r;
  // Store bookkeeping.
  logic [TAG_W-1:0]         epoch_r;
  logic [ADDR_W-1:0]        sweep_cnt_r;
  // Result register.
  logic                     out_valid_r, out_filled_r;
  logic [DATA_W-1:0]        out_depth_r, out_a_r, out_b_r, out_c_r;

  logic [WORD_W-1:0] mem [DEPTH_N];

  logic signed [PROD_W-1:0] rnd_row, rnd_col, sh_row, sh_col;
  logic signed [POS_W-1:0]  tgt_row, tgt_col, lim_row, lim_col;
  logic                     in_range;
  logic [TAG_W-1:0]         st_tag;
  logic [DATA_W-1:0]        st_depth, st_a, st_b, st_c;
  logic                     hit, wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic [WORD_W-1:0]        wr_data;

  // Round half up, then floor through the arithmetic shift.
  assign rnd_row = prod_row_r + $signed(HALF);
  assign rnd_col = prod_col_r + $signed(HALF);
  assign sh_row  = rnd_row >>> RND;
  assign sh_col  = rnd_col >>> RND;

  assign tgt_row = $signed({{(POS_W-COORD_W){1'b0}}, row_r})
                 + (cmd.use_shift ? {{(POS_W-PROD_W){sh_row[PROD_W-1]}}, sh_row}
                                  : POS_W'(0));
  assign tgt_col = $signed({{(POS_W-COORD_W){1'b0}}, col_r})
                 + (cmd.use_shift ? {{(POS_W-PROD_W){sh_col[PROD_W-1]}}, sh_col}
                                  : POS_W'(0));

  assign lim_row = (cfg.rows_in_use > MAX_ROWS) ? POS_W'(MAX_ROWS) : POS_W'(cfg.rows_in_use);
  assign lim_col = (cfg.cols_in_use > MAX_COLS) ? POS_W'(MAX_COLS) : POS_W'(cfg.cols_in_use);

  assign in_range = !tgt_row[POS_W-1] && !tgt_col[POS_W-1]
                 && (tgt_row < lim_row) && (tgt_col < lim_col);

  assign st_tag   = rd_word_r[WORD_W-1 -: TAG_W];
  assign st_depth = rd_word_r[4*DATA_W-1 -: DATA_W];
  assign st_a     = rd_word_r[3*DATA_W-1 -: DATA_W];
  assign st_b     = rd_word_r[2*DATA_W-1 -: DATA_W];
  assign st_c     = rd_word_r[DATA_W-1 -: DATA_W];
  // An entry only counts when it was written during the current frame.
  assign hit      = (st_tag == epoch_r);

  assign wr_en   = cmd.sweep || (cmd.upd && in_range_r && (!hit || (st_depth < depth_r)));
  assign wr_addr = cmd.sweep ? sweep_cnt_r : addr_r;
  assign wr_data = cmd.sweep ? '0 : {epoch_r, depth_r, col_a_r, col_b_r, col_c_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_r   <= in_row;
      col_r   <= in_col;
      depth_r <= in_pixel_depth;
      disp_r  <= $signed({1'b0, in_pixel_depth}) - $signed({1'b0, cfg.depth_offset});
      col_a_r <= (cfg.components >= 2'd1) ? in_color_a : '0;
      col_b_r <= (cfg.components >= 2'd2) ? in_color_b : '0;
      col_c_r <= (cfg.components >= 2'd3) ? in_color_c : '0;
    end
    if (cmd.mul) begin
      prod_row_r <= PROD_W'(disp_r) * PROD_W'($signed(cfg.row_offset));
      prod_col_r <= PROD_W'(disp_r) * PROD_W'($signed(cfg.col_offset));
    end
    if (cmd.addr) begin
      addr_r     <= {tgt_row[ROW_W-1:0], tgt_col[COL_W-1:0]};
      in_range_r <= in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_word_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r     <= TAG_W'(1);
      sweep_cnt_r <= '0;
    end else begin
      if (cmd.epoch_step) begin
        epoch_r <= (&epoch_r) ? TAG_W'(1) : epoch_r + TAG_W'(1);
      end
      if (cmd.sweep) begin
        sweep_cnt_r <= sweep_cnt_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.resp) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      out_filled_r <= in_range_r && hit;
      out_depth_r  <= (in_range_r && hit) ? st_depth : '0;
      out_a_r      <= (in_range_r && hit) ? st_a : '0;
      out_b_r      <= (in_range_r && hit) ? st_b : '0;
      out_c_r      <= (in_range_r && hit) ? st_c : '0;
    end
  end

  assign status.epoch_max  = &epoch_r;
  assign status.sweep_last = &sweep_cnt_r;
  assign status.out_busy   = out_valid_r && out_stall;

  assign out_valid   = out_valid_r;
  assign out_filled  = out_filled_r;
  assign out_depth   = out_depth_r;
  assign out_color_a = out_a_r;
  assign out_color_b = out_b_r;
  assign out_color_c = out_c_r;

  `DFW_ASSERT(a_epoch_nz, epoch_r != '0, "frame tag reached the empty code")
  `DFW_ASSERT(a_wr_range, !(wr_en && !cmd.sweep) || in_range_r, "store written off the image")

endmodule

// ===== hw/rtl/depth_forward_warp_zbuffer_top.sv =====
// Forward warp with z-buffer. Each word on the in_ channel is one action:
// start (clears the target store, no result), warp (moves one source pixel
// into the target view and keeps it if it is nearer, no result) or read
// (one result word with the stored pixel or zeros when the entry is empty
// or off the image). Items are handled one at a time by a small sequencer
// around one z-buffer memory: a warp steps through accept, multiply,
// address, memory read, and compare and write; a read through accept,
// address, memory read and result, with any wait on out_stall; start and
// unused actions end at accept. Per-entry frame tags mean a start normally
// needs no sweep; after reset, and on every 255th start, the block sweeps
// all 2^(ROW_W+COL_W) entries (262144 at the default size) with in_stall
// high. Configuration writes are taken at any time through cfg_ready, which
// is always high, but should only be made while the block is idle.
module depth_forward_warp_zbuffer_top
  import dfw_pkg::*;
#(
  parameter int MAX_ROWS        = 512,
  parameter int MAX_COLS        = 512,
  parameter int DEPTH_FRAC_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_action,
  input  logic [COORD_W-1:0]   in_row,
  input  logic [COORD_W-1:0]   in_col,
  input  logic [DATA_W-1:0]    in_pixel_depth,
  input  logic [DATA_W-1:0]    in_color_a,
  input  logic [DATA_W-1:0]    in_color_b,
  input  logic [DATA_W-1:0]    in_color_c,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_filled,
  output logic [DATA_W-1:0]    out_depth,
  output logic [DATA_W-1:0]    out_color_a,
  output logic [DATA_W-1:0]    out_color_b,
  output logic [DATA_W-1:0]    out_color_c
);

  cfg_t    cfg_r;
  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.col_offset   <= '0;
      cfg_r.row_offset   <= '0;
      cfg_r.depth_offset <= '0;
      cfg_r.rows_in_use  <= SIZE_W'(512);
      cfg_r.cols_in_use  <= SIZE_W'(512);
      cfg_r.components   <= COMP_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COL_OFFSET:   cfg_r.col_offset   <= cfg_data;
        REG_ROW_OFFSET:   cfg_r.row_offset   <= cfg_data;
        REG_DEPTH_OFFSET: cfg_r.depth_offset <= cfg_data;
        REG_ROWS_IN_USE:  cfg_r.rows_in_use  <= cfg_data[SIZE_W-1:0];
        REG_COLS_IN_USE:  cfg_r.cols_in_use  <= cfg_data[SIZE_W-1:0];
        REG_COMPONENTS:   cfg_r.components   <= cfg_data[COMP_W-1:0];
        default: ;
      endcase
    end
  end

  dfw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .status    (status),
    .cmd       (cmd)
  );

  dfw_dp #(
    .MAX_ROWS        (MAX_ROWS),
    .MAX_COLS        (MAX_COLS),
    .DEPTH_FRAC_BITS (DEPTH_FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg            (cfg_r),
    .in_row         (in_row),
    .in_col         (in_col),
    .in_pixel_depth (in_pixel_depth),
    .in_color_a     (in_color_a),
    .in_color_b     (in_color_b),
    .in_color_c     (in_color_c),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_filled     (out_filled),
    .out_depth      (out_depth),
    .out_color_a    (out_color_a),
    .out_color_b    (out_color_b),
    .out_color_c    (out_color_c)
  );

endmodule
